>>> src/xks_pkg.sv
`default_nettype none
package xks_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned NUM_WORDS = 5;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned SKIP_W   = 4;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [SKIP_W-1:0] skip_type;

   // seeding offsets for words one to four
   localparam word_type SEED_OFS_1 = 32'h159a_55e5;
   localparam word_type SEED_OFS_2 = 32'h1f12_3bb5;
   localparam word_type SEED_OFS_3 = 32'h0549_1333;
   localparam word_type SEED_OFS_4 = 32'h34da_d465;

   // commands from the controller to the datapath
   typedef struct packed {
      logic seed_load;  // load generator words from seed, hold data and last
      logic step;       // advance the generator by one output
      logic emit;       // write the output register
      logic use_held;   // emit from the held request instead of the live one
      logic mix_key;    // XOR the keystream byte in; also marks next byte odd
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic     odd_position;
      logic     out_busy;
      skip_type skip;
   } status_type;

   // new fifth word of the xorshift generator
   function automatic word_type gen_top(input word_type first, input word_type top);
      word_type mix;
      mix = first ^ (first >> 7);
      return mix ^ (mix << 13) ^ top ^ (top << 6);
   endfunction

   // low byte of top * (2 * keep + 1); only low operand bytes matter mod 2^8
   function automatic byte_type key_byte(input word_type top, input word_type keep);
      logic [2*BYTE_W-1:0] prod;
      prod = {{BYTE_W{1'b0}}, top[BYTE_W-1:0]} *
             {{BYTE_W{1'b0}}, keep[BYTE_W-2:0], 1'b1};
      return prod[BYTE_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> src/xks_ctrl.sv
`default_nettype none
module xks_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire                     req_start_req,
   output logic                    req_ready,
   input  xks_pkg::status_type     status,
   output xks_pkg::cmd_type        cmd
);
   import xks_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FIRST = 2'd1;
   localparam logic [1:0] ST_SKIP  = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0] state_ff, state_in;
   skip_type   cnt_ff, cnt_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE) && !status.out_busy;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_start_req) begin
                  cmd.seed_load = 1'b1;
                  state_in      = ST_FIRST;
               end else begin
                  cmd.emit    = 1'b1;
                  cmd.step    = !status.odd_position;
                  cmd.mix_key = !status.odd_position;
               end
            end
         end
         ST_FIRST: begin
            // first output sets the skip count
            cmd.step = 1'b1;
            cnt_in   = status.skip;
            state_in = (status.skip == '0) ? ST_EMIT : ST_SKIP;
         end
         ST_SKIP: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == skip_type'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.step     = 1'b1;
            cmd.emit     = 1'b1;
            cmd.use_held = 1'b1;
            cmd.mix_key  = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

>>> src/xks_dp.sv
`default_nettype none
module xks_dp (
   input  wire                     clock,
   input  wire                     reset,
   input  xks_pkg::cmd_type        cmd,
   output xks_pkg::status_type     status,
   input  wire  [31:0]             req_seed,
   input  wire  [7:0]              req_data_in,
   input  wire                     req_last_in,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output logic [7:0]              rsp_data_out,
   output logic                    rsp_last_out
);
   import xks_pkg::*;

   word_type words_ff [NUM_WORDS];
   word_type words_in [NUM_WORDS];
   byte_type hold_data_ff;
   logic     hold_last_ff;
   logic     odd_ff, odd_in;
   logic     valid_ff, valid_in;
   byte_type data_ff, data_in;
   logic     last_ff, last_in;

   word_type top;
   byte_type key;
   byte_type src_data;

   assign top = gen_top(words_ff[0], words_ff[NUM_WORDS-1]);
   assign key = key_byte(top, words_ff[2]);

   always_comb begin
      words_in = words_ff;
      if (cmd.seed_load) begin
         words_in[0] = req_seed;
         words_in[1] = (req_seed >> 1) + SEED_OFS_1;
         words_in[2] = (req_seed >> 3) + SEED_OFS_2;
         words_in[3] = (req_seed >> 5) + SEED_OFS_3;
         words_in[4] = (req_seed >> 7) + SEED_OFS_4;
      end else if (cmd.step) begin
         words_in[0] = words_ff[1];
         words_in[1] = words_ff[2];
         words_in[2] = words_ff[3];
         words_in[3] = words_ff[4];
         words_in[4] = top;
      end
   end

   assign src_data = cmd.use_held ? hold_data_ff : req_data_in;

   always_comb begin
      odd_in   = odd_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_ready;
      if (cmd.emit) begin
         odd_in   = cmd.mix_key;
         data_in  = src_data ^ (cmd.mix_key ? key : '0);
         last_in  = cmd.use_held ? hold_last_ff : req_last_in;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            words_ff[i] <= '0;
         end
         odd_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         words_ff <= words_in;
         odd_ff   <= odd_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.seed_load) begin
         hold_data_ff <= req_data_in;
         hold_last_ff <= req_last_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign status.odd_position = odd_ff;
   assign status.out_busy     = valid_ff && !rsp_ready;
   assign status.skip         = key[SKIP_W-1:0];

   assign rsp_valid    = valid_ff;
   assign rsp_data_out = data_ff;
   assign rsp_last_out = last_ff;

endmodule
`default_nettype wire

>>> src/xorshift_keystream_alt_byte_xor_top.sv
// A byte without start is in the output register in the cycle after it is taken.
// A start byte is seeded, then ST_FIRST draws and sets skip, 0 to 15 (low four bits
// of the keystream byte), ST_SKIP draws skip more times and ST_EMIT draws and emits.
// Throughput: one byte per cycle for bytes without start while the output is not held.
// Reset (synchronous, active high) zeroes the generator words, the position flag,
// the controller state and the output valid.
`default_nettype none
module xorshift_keystream_alt_byte_xor_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_start_req,
   input  wire  [31:0] req_seed,
   input  wire  [7:0]  req_data_in,
   input  wire         req_last_in,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [7:0]  rsp_data_out,
   output logic        rsp_last_out
);
   import xks_pkg::*;

   // Controller decides when to seed, draw and emit; the datapath holds the
   // five generator words, the position flag and the output register.
   cmd_type    cmd;
   status_type status;

   // Take a request only when the controller is idle and the output register
   // is empty or being drained in the same cycle.
   xks_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_start_req (req_start_req),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   // Even-position bytes advance the generator and get XORed with the keystream byte;
   // odd-position bytes pass unchanged and hold the state.
   xks_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_seed     (req_seed),
      .req_data_in  (req_data_in),
      .req_last_in  (req_last_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data_out (rsp_data_out),
      .rsp_last_out (rsp_last_out)
   );

endmodule
`default_nettype wire

>>> src/xks_chk.sv
`default_nettype none
module xks_chk (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        req_start_req,
   input wire [31:0] req_seed,
   input wire [7:0]  req_data_in,
   input wire        req_last_in,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [7:0]  rsp_data_out,
   input wire        rsp_last_out
);
   logic [1:0] pend_ff, pend_in;
   logic       par_ff, par_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff + {1'b0, req_acc} - {1'b0, rsp_acc};
      par_in  = par_ff;
      if (req_acc) begin
         par_in = req_start_req ? 1'b1 : !par_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         par_ff  <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         par_ff  <= par_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out) && $stable(rsp_last_out))
      else $error("held response changed");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 2'd1)
      else $error("more than one request in flight");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff == 2'd1)
      else $error("response without request");

   a_odd_pass: assert property (@(posedge clock) disable iff (reset)
      req_acc && !req_start_req && par_ff |=>
         rsp_valid && rsp_data_out == $past(req_data_in) && rsp_last_out == $past(req_last_in))
      else $error("odd-position byte not passed through");

   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> pend_ff == 2'd0 || rsp_acc)
      else $error("ready while a request is still pending");

endmodule

bind xorshift_keystream_alt_byte_xor_top xks_chk u_xks_chk (.*);
`default_nettype wire
